FILE: hdl/ase_pkg.sv
// Shared types, opcode constants and decoded-instruction layout for the ARM subset core.
`timescale 1ns / 1ps
`default_nettype none

package ase_pkg;

  // Register file geometry.
  localparam int          NUM_REGS = 16;
  localparam logic [3:0]  REG_PC   = 4'd15;
  localparam logic [3:0]  REG_LR   = 4'd14;

  // Condition field value that never executes in this subset.
  localparam logic [3:0]  COND_NV  = 4'hF;

  // Instruction class, bits 27:25.
  localparam logic [2:0]  CLS_DP_IMM = 3'd1;
  localparam logic [2:0]  CLS_MEM    = 3'd2;
  localparam logic [2:0]  CLS_BRANCH = 3'd5;

  // Data processing opcodes, bits 24:21.
  localparam logic [3:0]  DP_SUB = 4'd2;
  localparam logic [3:0]  DP_MOV = 4'd13;

  // Work kinds handed from the front end to the execute stage.
  localparam logic [2:0]  KIND_UNDEF   = 3'd0;
  localparam logic [2:0]  KIND_NV      = 3'd1;
  localparam logic [2:0]  KIND_BRANCH  = 3'd2;
  localparam logic [2:0]  KIND_MOV     = 3'd3;
  localparam logic [2:0]  KIND_SUB     = 3'd4;
  localparam logic [2:0]  KIND_MEM     = 3'd5;
  localparam logic [2:0]  KIND_LOADRET = 3'd6;

  // One classified word as it sits in the queue.
  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  cond;
    logic [3:0]  rn;
    logic [3:0]  rd;
    logic        link;
    logic [23:0] br_off;
    logic [31:0] imm;
    logic        rot_nz;
    logic        flag_update;
    logic        pre;
    logic        up;
    logic        byte_acc;
    logic        wb;
    logic        load;
    logic [11:0] off;
    logic [31:0] load_data;
  } ase_op_t;

endpackage

`default_nettype wire

FILE: hdl/ase_decode.sv
// Front end: classifies an incoming word and expands its immediate fields.
`timescale 1ns / 1ps
`default_nettype none

module ase_decode
  import ase_pkg::*;
(
  input  wire logic        cmd,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] load_data,
  output ase_op_t          op
);

  logic [4:0]  rot_amt;
  logic [63:0] imm_dbl;
  logic [63:0] imm_shifted;

  // Rotate right of the 8-bit immediate by twice the rotate field.
  assign rot_amt     = {instruction[11:8], 1'b0};
  assign imm_dbl     = {24'd0, instruction[7:0], 24'd0, instruction[7:0]};
  assign imm_shifted = imm_dbl >> rot_amt;

  always_comb begin
    op             = '0;
    op.cond        = instruction[31:28];
    op.rn          = instruction[19:16];
    op.rd          = instruction[15:12];
    op.link        = instruction[24];
    op.br_off      = instruction[23:0];
    op.imm         = imm_shifted[31:0];
    op.rot_nz      = |instruction[11:8];
    op.flag_update = instruction[20];
    op.pre         = instruction[24];
    op.up          = instruction[23];
    op.byte_acc    = instruction[22];
    op.wb          = instruction[21];
    op.load        = instruction[20];
    op.off         = instruction[11:0];
    op.load_data   = load_data;

    if (cmd) begin
      op.kind = KIND_LOADRET;
    end else if (instruction[31:28] == COND_NV) begin
      op.kind = KIND_NV;
    end else begin
      unique case (instruction[27:25])
        CLS_BRANCH: op.kind = KIND_BRANCH;
        CLS_MEM:    op.kind = KIND_MEM;
        CLS_DP_IMM: begin
          if (instruction[24:21] == DP_MOV) begin
            op.kind = KIND_MOV;
          end else if (instruction[24:21] == DP_SUB) begin
            op.kind = KIND_SUB;
          end else begin
            op.kind = KIND_UNDEF;
          end
        end
        default:    op.kind = KIND_UNDEF;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ase_queue.sv
// Small FIFO of classified words between the front end and the execute stage.
`timescale 1ns / 1ps
`default_nettype none

module ase_queue
  import ase_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  ase_op_t   push_op,
  output logic      not_full,
  input  wire logic pop,
  output logic      not_empty,
  output ase_op_t   head_op
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ase_op_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign not_full  = (count != CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head_op   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count can never pass the number of slots.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count exceeds depth");

endmodule

`default_nettype wire

FILE: hdl/ase_execute.sv
// Back end: register file, flags, program counter, pending load and result register.
`timescale 1ns / 1ps
`default_nettype none

module ase_execute
  import ase_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  ase_op_t          q_op,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      fetch_address,
  output logic             mem_valid,
  output logic             mem_write,
  output logic             mem_byte,
  output logic [31:0]      mem_address,
  output logic [31:0]      mem_wdata,
  output logic             executed,
  output logic             undefined_instr,
  output logic [3:0]       flags_nzcv
);

  function automatic logic cond_pass(input logic [3:0] c, input logic [3:0] f);
    logic n;
    logic z;
    logic cf;
    logic v;
    logic r;
    n  = f[3];
    z  = f[2];
    cf = f[1];
    v  = f[0];
    unique case (c)
      4'd0:    r = z;
      4'd1:    r = !z;
      4'd2:    r = cf;
      4'd3:    r = !cf;
      4'd4:    r = n;
      4'd5:    r = !n;
      4'd6:    r = v;
      4'd7:    r = !v;
      4'd8:    r = cf && !z;
      4'd9:    r = !cf || z;
      4'd10:   r = (n == v);
      4'd11:   r = (n != v);
      4'd12:   r = !z && (n == v);
      4'd13:   r = z || (n != v);
      4'd14:   r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Architectural state.
  logic [31:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] rf_written;
  logic [31:0]         pc;
  logic [3:0]          flags;
  logic [3:0]          pend_dest;
  logic                pend_valid;
  logic                pend_skip;

  // Execute stage register and its operand reads.
  logic                ex_valid;
  ase_op_t             ex_op;
  logic [31:0]         rn_data;
  logic [31:0]         rd_data;
  logic                fire;
  logic                ex_load;

  // Next-state and result signals.
  logic [31:0]         pc_next;
  logic [3:0]          flags_next;
  logic [3:0]          pend_dest_next;
  logic                pend_valid_next;
  logic                pend_skip_next;
  logic                wr_en;
  logic [3:0]          wr_idx;
  logic [31:0]         wr_val;
  logic                mv;
  logic                mw;
  logic                mb;
  logic [31:0]         ma;
  logic [31:0]         md;
  logic                ex;
  logic                und;

  // Datapath temporaries.
  logic [31:0]         opa;
  logic [31:0]         opd;
  logic [32:0]         diff;
  logic [31:0]         off32;
  logic [31:0]         moved;
  logic                dowb;
  logic                rf_we;

  assign fire    = ex_valid && (!out_valid || out_ready);
  assign ex_load = q_valid && (!ex_valid || fire);
  assign q_pop   = ex_load;
  assign rf_we   = fire && wr_en && (wr_idx != REG_PC);

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (ex_load) begin
      ex_valid <= 1'b1;
    end else if (fire) begin
      ex_valid <= 1'b0;
    end
  end

  // Register file: one write port, two registered read ports. A write at the
  // same edge as the read is forwarded so back-to-back words see it.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[wr_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_written <= '0;
    end else if (rf_we) begin
      rf_written[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_load) begin
      ex_op <= q_op;
      if (rf_we && (wr_idx == q_op.rn)) begin
        rn_data <= wr_val;
      end else begin
        rn_data <= rf_written[q_op.rn] ? rf_mem[q_op.rn] : '0;
      end
      if (rf_we && (wr_idx == q_op.rd)) begin
        rd_data <= wr_val;
      end else begin
        rd_data <= rf_written[q_op.rd] ? rf_mem[q_op.rd] : '0;
      end
    end
  end

  always_comb begin
    opa   = (ex_op.rn == REG_PC) ? pc + 32'd8 : rn_data;
    opd   = (ex_op.rd == REG_PC) ? pc + 32'd8 : rd_data;
    diff  = {1'b0, opa} - {1'b0, ex_op.imm};
    off32 = {20'd0, ex_op.off};
    moved = ex_op.up ? opa + off32 : opa - off32;
    dowb  = !ex_op.pre || ex_op.wb;

    pc_next         = pc;
    flags_next      = flags;
    pend_dest_next  = pend_dest;
    pend_valid_next = pend_valid;
    pend_skip_next  = pend_skip;
    wr_en           = 1'b0;
    wr_idx          = ex_op.rd;
    wr_val          = '0;
    mv              = 1'b0;
    mw              = 1'b0;
    mb              = 1'b0;
    ma              = '0;
    md              = '0;
    ex              = 1'b0;
    und             = 1'b0;

    case (ex_op.kind)
      KIND_LOADRET: begin
        if (pend_valid) begin
          if (!pend_skip) begin
            wr_en  = 1'b1;
            wr_idx = pend_dest;
            wr_val = (pend_dest == REG_PC) ? {ex_op.load_data[31:2], 2'b00}
                                           : ex_op.load_data;
          end
          pend_valid_next = 1'b0;
          pend_skip_next  = 1'b0;
          ex              = 1'b1;
        end
      end
      KIND_NV: begin
        und = 1'b1;
      end
      default: begin
        if (!cond_pass(ex_op.cond, flags)) begin
          pc_next = pc + 32'd4;
        end else begin
          pc_next = pc + 32'd4;
          unique case (ex_op.kind)
            KIND_BRANCH: begin
              if (ex_op.link) begin
                wr_en  = 1'b1;
                wr_idx = REG_LR;
                wr_val = pc + 32'd4;
              end
              pc_next = pc + 32'd8 + {{6{ex_op.br_off[23]}}, ex_op.br_off, 2'b00};
              ex      = 1'b1;
            end
            KIND_MOV: begin
              wr_en  = 1'b1;
              wr_val = ex_op.imm;
              if (ex_op.flag_update) begin
                flags_next = {ex_op.imm[31], (ex_op.imm == '0),
                              ex_op.rot_nz ? ex_op.imm[31] : flags[1], flags[0]};
              end
              ex = 1'b1;
            end
            KIND_SUB: begin
              wr_en  = 1'b1;
              wr_val = diff[31:0];
              if (ex_op.flag_update) begin
                flags_next = {diff[31], (diff[31:0] == '0), !diff[32],
                              (opa[31] ^ ex_op.imm[31]) & (opa[31] ^ diff[31])};
              end
              ex = 1'b1;
            end
            KIND_MEM: begin
              mv = 1'b1;
              mb = ex_op.byte_acc;
              ma = ex_op.pre ? moved : opa;
              if (ex_op.load) begin
                pend_dest_next  = ex_op.rd;
                pend_valid_next = 1'b1;
                pend_skip_next  = dowb && (ex_op.rn == ex_op.rd);
              end else begin
                mw = 1'b1;
                md = ex_op.byte_acc ? {24'd0, opd[7:0]} : opd;
              end
              if (dowb) begin
                wr_en  = 1'b1;
                wr_idx = ex_op.rn;
                wr_val = (ex_op.rn == REG_PC) ? {moved[31:2], 2'b00} : moved;
              end
              ex = 1'b1;
            end
            default: begin
              und     = 1'b1;
              pc_next = pc;
            end
          endcase
        end
      end
    endcase

    // A register write to r15 redirects the program counter.
    if (wr_en && (wr_idx == REG_PC)) begin
      pc_next = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      flags      <= '0;
      pend_dest  <= '0;
      pend_valid <= 1'b0;
      pend_skip  <= 1'b0;
    end else if (fire) begin
      pc         <= pc_next;
      flags      <= flags_next;
      pend_dest  <= pend_dest_next;
      pend_valid <= pend_valid_next;
      pend_skip  <= pend_skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fetch_address   <= pc_next;
      mem_valid       <= mv;
      mem_write       <= mw;
      mem_byte        <= mb;
      mem_address     <= ma;
      mem_wdata       <= md;
      executed        <= ex;
      undefined_instr <= und;
      flags_nzcv      <= flags_next;
    end
  end

  // A skipped load return only makes sense while a load is outstanding.
  a_skip_needs_pending: assert property (@(posedge clk) disable iff (rst)
    pend_skip |-> pend_valid)
    else $error("pending skip set without a pending load");

  // An undefined word leaves the program counter where it was.
  a_undef_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (fire && und) |=> (fetch_address == $past(pc)))
    else $error("undefined word moved the program counter");

  // Without a memory request the request fields of the result are all zero.
  a_idle_mem_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mem_valid) |->
      (!mem_write && !mem_byte && (mem_address == '0) && (mem_wdata == '0)))
    else $error("memory fields set without a request");

  // A word is never both executed and undefined.
  a_exec_or_undef: assert property (@(posedge clk) disable iff (rst)
    fire |=> !(executed && undefined_instr))
    else $error("result both executed and undefined");

endmodule

`default_nettype wire

FILE: hdl/arm_subset_instruction_execute.sv
// Top level of the ARM subset executor: front-end decode, word queue and execute stage.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------------
// input    in_valid / in_ready   cmd, instruction, load_data
// output   out_valid / out_ready fetch_address, mem_valid, mem_write, mem_byte,
//                                mem_address, mem_wdata, executed,
//                                undefined_instr, flags_nzcv
//
// One input word is taken per cycle and one result word leaves per cycle while
// out_ready stays high; the execute stage then finishes one word per cycle, its
// register reads being registered as the word enters the stage, with forwarding
// from the write at that edge. A word passes a queue slot, the stage register and
// the result register in turn. rst (synchronous, active high) clears the registers,
// flags, program counter, pending load, queue and both valid flags.
// A stall on the output holds the execute stage; the queue then fills and
// in_ready drops only when all QUEUE_DEPTH slots hold words.

module arm_subset_instruction_execute
  import ase_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] instruction,
  input  wire logic [31:0] load_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      fetch_address,
  output logic             mem_valid,
  output logic             mem_write,
  output logic             mem_byte,
  output logic [31:0]      mem_address,
  output logic [31:0]      mem_wdata,
  output logic             executed,
  output logic             undefined_instr,
  output logic [3:0]       flags_nzcv
);

  // Front end: each word is classified as soon as it arrives.
  ase_op_t dec_op;
  ase_op_t head_op;
  logic    q_valid;
  logic    q_pop;

  ase_decode u_decode (
    .cmd         (cmd),
    .instruction (instruction),
    .load_data   (load_data),
    .op          (dec_op)
  );

  // The queue lets the front end keep accepting while the back end stalls.
  ase_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_op   (dec_op),
    .not_full  (in_ready),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head_op   (head_op)
  );

  // Back end: all architectural state and the result register live here.
  ase_execute u_execute (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_op            (head_op),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fetch_address   (fetch_address),
    .mem_valid       (mem_valid),
    .mem_write       (mem_write),
    .mem_byte        (mem_byte),
    .mem_address     (mem_address),
    .mem_wdata       (mem_wdata),
    .executed        (executed),
    .undefined_instr (undefined_instr),
    .flags_nzcv      (flags_nzcv)
  );

endmodule

`default_nettype wire
